FILE: rtl/itoa_pkg.sv
`default_nettype none

package itoa_pkg;

	// Fixed field widths of the stream channels.
	localparam int unsigned VALUE_W = 32;
	localparam int unsigned OP_W    = 2;
	localparam int unsigned CHAR_W  = 8;

	// Widest value the converter is built for, and the parameter defaults.
	localparam int unsigned MAX_VALUE_BITS     = 64;
	localparam int unsigned DEF_VALUE_BITS     = 32;
	localparam int unsigned DEF_MAX_DIGITS     = 10;

	// Format selector codes carried in tuser.
	localparam logic [OP_W-1:0] OP_UDEC  = 2'd0;
	localparam logic [OP_W-1:0] OP_SBYTE = 2'd1;
	localparam logic [OP_W-1:0] OP_HEX   = 2'd2;

	// Character codes.
	localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CH_LOW_A = 8'h61;
	localparam logic [CHAR_W-1:0] CH_X     = 8'h78;

	// Status from the converter to the sequencer in the top level.
	typedef struct packed {
		logic done;
		logic ovf;
	} dab_stat_t;

	// Start command from the top level to the character emitter.
	typedef struct packed {
		logic start;
		logic hex;
		logic ovf;
	} emit_ctl_t;

	// One nibble to its lower-case hex character; decimal digits map to '0'..'9'.
	function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] nib);
		logic [CHAR_W-1:0] ch;
		if (nib > 4'd9) begin
			ch = CH_LOW_A + {4'b0000, nib - 4'd10};
		end else begin
			ch = CH_ZERO + {4'b0000, nib};
		end
		return ch;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/integer_to_ascii_formatter_unit.sv
// Integer to ASCII formatter.
// Input stream: each request carries a 32-bit number in s_axis_tdata and a
// format selector in s_axis_tuser (0 unsigned decimal, 1 magnitude of the
// signed low byte in decimal, 2 low byte as "0x" and two lower-case hex
// digits, 3 produces no characters).
// Output stream: one ASCII character per transfer in m_axis_tdata, most
// significant first, with m_axis_tlast on the final character of the run.
// Decimal formats run a bit-serial shift-and-add-3 converter, one bit per
// cycle, then drop leading zeros one at a time; then one character per
// cycle while the receiver keeps up. One request is worked on at a time;
// s_axis_tready rises again once the emitter is idle after the last
// character of the current run is loaded into the output register and the
// sequencer has returned to T_IDLE, so the next conversion overlaps with
// that character waiting. When the receiver stalls, the output register
// holds its character and the emitter waits. Reset clears all control
// state and drops m_axis_tvalid.
`default_nettype none

module integer_to_ascii_formatter_unit #(
	parameter int unsigned VALUE_BITS = itoa_pkg::DEF_VALUE_BITS,
	parameter int unsigned MAX_DIGITS = itoa_pkg::DEF_MAX_DIGITS
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                s_axis_tvalid,
	output logic                               s_axis_tready,
	input  wire  [itoa_pkg::VALUE_W-1:0]       s_axis_tdata,  // [31:0] value
	input  wire  [itoa_pkg::OP_W-1:0]          s_axis_tuser,  // [1:0] op
	output logic                               m_axis_tvalid,
	input  wire                                m_axis_tready,
	output logic [itoa_pkg::CHAR_W-1:0]        m_axis_tdata,  // [7:0] char_code
	output logic                               m_axis_tlast
);

	typedef enum logic [1:0] {
		T_IDLE,
		T_CONV,
		T_EMIT
	} state_t;

	state_t                    state_q;
	logic                      accept;
	logic                      dab_start;
	logic [VALUE_BITS-1:0]     load_val;
	logic [7:0]                byte_mag;
	logic [4*MAX_DIGITS-1:0]   bcd;
	itoa_pkg::dab_stat_t       dab_st;
	itoa_pkg::emit_ctl_t       emit_ctl;
	logic                      emit_busy;

	assign s_axis_tready = (state_q == T_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;

	// The most negative byte has no positive twin in eight bits, but its
	// two's complement reads as 128 unsigned, which is the wanted magnitude.
	assign byte_mag = s_axis_tdata[7] ? (~s_axis_tdata[7:0] + 8'd1) : s_axis_tdata[7:0];

	always_comb begin
		if (s_axis_tuser == itoa_pkg::OP_SBYTE) begin
			load_val = VALUE_BITS'(byte_mag);
		end else begin
			load_val = VALUE_BITS'({{(itoa_pkg::MAX_VALUE_BITS - itoa_pkg::VALUE_W){1'b0}},
				s_axis_tdata});
		end
	end

	assign dab_start = accept && (s_axis_tuser == itoa_pkg::OP_UDEC ||
		s_axis_tuser == itoa_pkg::OP_SBYTE);

	// Hex requests go straight to the emitter; decimal runs start when the
	// converter finishes.
	always_comb begin
		emit_ctl.hex   = (state_q == T_IDLE);
		emit_ctl.ovf   = dab_st.ovf;
		emit_ctl.start = (accept && s_axis_tuser == itoa_pkg::OP_HEX) ||
			(state_q == T_CONV && dab_st.done);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= T_IDLE;
		end else begin
			unique case (state_q)
				T_IDLE: begin
					if (dab_start) begin
						state_q <= T_CONV;
					end else if (accept && s_axis_tuser == itoa_pkg::OP_HEX) begin
						state_q <= T_EMIT;
					end
				end
				T_CONV: begin
					if (dab_st.done) begin
						state_q <= T_EMIT;
					end
				end
				T_EMIT: begin
					if (!emit_busy) begin
						state_q <= T_IDLE;
					end
				end
				default: begin
					state_q <= T_IDLE;
				end
			endcase
		end
	end

	itoa_dabble #(
		.VALUE_BITS (VALUE_BITS),
		.MAX_DIGITS (MAX_DIGITS)
	) u_dabble (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (dab_start),
		.load_val (load_val),
		.bcd      (bcd),
		.stat     (dab_st)
	);

	itoa_emit #(
		.MAX_DIGITS (MAX_DIGITS)
	) u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (emit_ctl),
		.digits   (bcd),
		.hex_byte (s_axis_tdata[7:0]),
		.busy     (emit_busy),
		.m_valid  (m_axis_tvalid),
		.m_ready  (m_axis_tready),
		.m_data   (m_axis_tdata),
		.m_last   (m_axis_tlast)
	);

`ifndef NO_ASSERTIONS
	// The emitter is never running while a conversion is in progress.
	a_conv_excl: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == T_CONV |-> !emit_busy)
		else $error("emitter busy during conversion");

	// The converter only reports completion while the sequencer waits for it.
	a_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		dab_st.done |-> state_q == T_CONV)
		else $error("converter done outside conversion state");

	// An accepted hex request starts the emitter on the next cycle.
	a_hex_start: assert property (@(posedge clk) disable iff (!arst_n)
		accept && s_axis_tuser == itoa_pkg::OP_HEX |=> emit_busy)
		else $error("hex request did not start the emitter");
`endif

endmodule

`default_nettype wire

FILE: rtl/itoa_dabble.sv
`default_nettype none

// Bit-serial binary to BCD converter (shift and add-3), one input bit per cycle.
module itoa_dabble #(
	parameter int unsigned VALUE_BITS = itoa_pkg::DEF_VALUE_BITS,
	parameter int unsigned MAX_DIGITS = itoa_pkg::DEF_MAX_DIGITS
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          start,
	input  wire  [VALUE_BITS-1:0]        load_val,
	output logic [4*MAX_DIGITS-1:0]      bcd,
	output itoa_pkg::dab_stat_t          stat
);

	localparam int unsigned BCD_W = 4 * MAX_DIGITS;
	localparam int unsigned CNT_W = $clog2(VALUE_BITS + 1);

	logic                 run_q;
	logic                 done_q;
	logic                 ovf_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [VALUE_BITS-1:0] bin_q;
	logic [BCD_W-1:0]     bcd_q;
	logic [BCD_W-1:0]     adj;

	// Every digit of five or more gets three added before the doubling shift.
	always_comb begin
		for (int d = 0; d < MAX_DIGITS; d++) begin
			if (bcd_q[4*d +: 4] >= 4'd5) begin
				adj[4*d +: 4] = bcd_q[4*d +: 4] + 4'd3;
			end else begin
				adj[4*d +: 4] = bcd_q[4*d +: 4];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			ovf_q  <= 1'b0;
			cnt_q  <= '0;
			bin_q  <= '0;
			bcd_q  <= '0;
		end else begin
			if (start) begin
				run_q  <= 1'b1;
				done_q <= 1'b0;
				ovf_q  <= 1'b0;
				cnt_q  <= CNT_W'(VALUE_BITS);
				bin_q  <= load_val;
				bcd_q  <= '0;
			end else if (run_q) begin
				// A bit leaving the top digit means the number has more digits
				// than the register keeps; the lower digits stay exact.
				bcd_q  <= {adj[BCD_W-2:0], bin_q[VALUE_BITS-1]};
				bin_q  <= bin_q << 1;
				ovf_q  <= ovf_q | adj[BCD_W-1];
				cnt_q  <= cnt_q - CNT_W'(1);
				done_q <= (cnt_q == CNT_W'(1));
				if (cnt_q == CNT_W'(1)) begin
					run_q <= 1'b0;
				end
			end else begin
				done_q <= 1'b0;
			end
		end
	end

	assign bcd       = bcd_q;
	assign stat.done = done_q;
	assign stat.ovf  = ovf_q;

endmodule

`default_nettype wire

FILE: rtl/itoa_emit.sv
`default_nettype none

// Character emitter: a digit per cycle while not stalled, into a registered output.
module itoa_emit #(
	parameter int unsigned MAX_DIGITS = itoa_pkg::DEF_MAX_DIGITS
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  itoa_pkg::emit_ctl_t                ctl,
	input  wire  [4*MAX_DIGITS-1:0]            digits,
	input  wire  [7:0]                         hex_byte,
	output logic                               busy,
	output logic                               m_valid,
	input  wire                                m_ready,
	output logic [itoa_pkg::CHAR_W-1:0]        m_data,
	output logic                               m_last
);

	localparam int unsigned BCD_W   = 4 * MAX_DIGITS;
	localparam int unsigned CNT_MAX = (MAX_DIGITS > 4) ? MAX_DIGITS : 4;
	localparam int unsigned CW      = $clog2(CNT_MAX + 1);

	typedef enum logic [1:0] {
		E_IDLE,
		E_SKIP,
		E_OUT
	} phase_t;

	phase_t                      phase_q;
	logic [BCD_W-1:0]            dig_q;
	logic [CW-1:0]               left_q;
	logic                        ovf_q;
	logic                        hex_q;
	logic                        valid_q;
	logic                        last_q;
	logic [itoa_pkg::CHAR_W-1:0] data_q;

	logic [3:0]                  top_nib;
	logic                        out_free;
	logic [BCD_W-1:0]            hex_load;
	logic [itoa_pkg::CHAR_W-1:0] next_char;

	assign top_nib  = dig_q[BCD_W-1 -: 4];
	assign out_free = !valid_q || m_ready;

	always_comb begin
		hex_load               = '0;
		hex_load[BCD_W-1 -: 8] = hex_byte;
	end

	always_comb begin
		if (hex_q && left_q == CW'(4)) begin
			next_char = itoa_pkg::CH_ZERO;
		end else if (hex_q && left_q == CW'(3)) begin
			next_char = itoa_pkg::CH_X;
		end else begin
			next_char = itoa_pkg::hex_char(top_nib);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= E_IDLE;
			dig_q   <= '0;
			left_q  <= '0;
			ovf_q   <= 1'b0;
			hex_q   <= 1'b0;
			valid_q <= 1'b0;
			last_q  <= 1'b0;
			data_q  <= '0;
		end else begin
			// While emitting, the output register is handled in the E_OUT arm.
			if (valid_q && m_ready && phase_q != E_OUT) begin
				valid_q <= 1'b0;
			end
			unique case (phase_q)
				E_IDLE: begin
					if (ctl.start) begin
						hex_q <= ctl.hex;
						ovf_q <= ctl.ovf;
						if (ctl.hex) begin
							dig_q   <= hex_load;
							left_q  <= CW'(4);
							phase_q <= E_OUT;
						end else begin
							dig_q   <= digits;
							left_q  <= CW'(MAX_DIGITS);
							phase_q <= E_SKIP;
						end
					end
				end
				E_SKIP: begin
					// Drop leading zeros, keeping at least one digit; a truncated
					// number keeps all of its digits.
					if (!ovf_q && left_q > CW'(1) && top_nib == 4'd0) begin
						dig_q  <= dig_q << 4;
						left_q <= left_q - CW'(1);
					end else begin
						phase_q <= E_OUT;
					end
				end
				E_OUT: begin
					if (out_free) begin
						valid_q <= 1'b1;
						data_q  <= next_char;
						last_q  <= (left_q == CW'(1));
						if (!hex_q || left_q <= CW'(2)) begin
							dig_q <= dig_q << 4;
						end
						left_q <= left_q - CW'(1);
						if (left_q == CW'(1)) begin
							phase_q <= E_IDLE;
						end
					end
				end
				default: begin
					phase_q <= E_IDLE;
				end
			endcase
		end
	end

	assign busy    = (phase_q != E_IDLE);
	assign m_valid = valid_q;
	assign m_data  = data_q;
	assign m_last  = last_q;

endmodule

`default_nettype wire

FILE: tb/sv/integer_to_ascii_formatter_unit_test.sv
`timescale 1ns / 1ps

// Testbench for the integer to ASCII formatter.
// A sender process offers requests (a number and a format selector) on the
// slave-side stream. A receiver process takes characters from the
// master-side stream. A small ledger class works out the characters that
// every accepted request must produce and checks each accepted character
// against the oldest one still owed.
module integer_to_ascii_formatter_unit_test;

	import itoa_pkg::*;

	// The selector code that produces no characters at all.
	localparam logic [OP_W-1:0] OP_NONE = 2'd3;

	localparam int RANDOM_REQUESTS = 350;
	// The last requests run with no idling on either side.
	localparam int CALM_REQUESTS   = 60;
	// The receiver holds off once for this many cycles, early in the run.
	localparam int HOLD_CYCLES     = 300;
	// Cycles allowed for a stray character after the last expected one.
	localparam int DRAIN_CYCLES    = 120;
	// Worst case per request: conversion and output, ten characters that each
	// wait out a receiver stall, and a sender gap, over around 400 requests.
	localparam int CYCLE_LIMIT     = 400000;

	typedef struct packed {
		logic [CHAR_W-1:0] code;
		logic              last;
	} char_item_t;

	// Holds the characters still owed by the block and checks the ones
	// that arrive.
	class char_ledger;
		char_item_t expected_chars[$];
		int         errors;

		function new();
			errors = 0;
		endfunction

		task report_mismatch(input string what);
			$display("MISMATCH at %0t: %s", $realtime, what);
			errors++;
		endtask

		// Queues the decimal digits of a number, most significant first.
		function void push_decimal(input logic [VALUE_W-1:0] num);
			logic [3:0]        digits[20];
			int                count;
			logic [VALUE_W-1:0] rest;
			char_item_t        item;
			count = 0;
			rest = num;
			if (rest == 0) begin
				digits[0] = 4'd0;
				count = 1;
			end
			while (rest != 0 && count < DEF_MAX_DIGITS) begin
				digits[count] = 4'(rest % 10);
				rest = rest / 10;
				count++;
			end
			while (count > 0) begin
				count--;
				item.code = CH_ZERO + {4'b0000, digits[count]};
				item.last = 1'b0;
				expected_chars.push_back(item);
			end
		endfunction

		function logic [CHAR_W-1:0] nibble_char(input logic [3:0] nib);
			if (nib >= 4'd10) begin
				return CH_LOW_A + {4'b0000, nib} - 8'd10;
			end
			return CH_ZERO + {4'b0000, nib};
		endfunction

		function void push_char(input logic [CHAR_W-1:0] code);
			char_item_t item;
			item.code = code;
			item.last = 1'b0;
			expected_chars.push_back(item);
		endfunction

		// Works out the run of characters for one accepted request.
		function void note_request(input logic [OP_W-1:0] op,
				input logic [VALUE_W-1:0] value);
			int        before_count;
			logic [7:0] low_byte;
			logic [7:0] magnitude;
			before_count = expected_chars.size();
			low_byte = value[7:0];
			case (op)
				OP_UDEC: begin
					push_decimal(value);
				end
				OP_SBYTE: begin
					// Two's complement negation; 0x80 negates to itself,
					// which read as unsigned is the wanted 128.
					magnitude = low_byte[7] ? 8'(-low_byte) : low_byte;
					push_decimal({24'd0, magnitude});
				end
				OP_HEX: begin
					push_char(CH_ZERO);
					push_char(CH_X);
					push_char(nibble_char(low_byte[7:4]));
					push_char(nibble_char(low_byte[3:0]));
				end
				default: begin
				end
			endcase
			if (expected_chars.size() > before_count) begin
				expected_chars[expected_chars.size() - 1].last = 1'b1;
			end
		endfunction

		// Compares one accepted character with the oldest one owed.
		task check_char(input logic [CHAR_W-1:0] code, input logic last);
			char_item_t want;
			if (expected_chars.size() == 0) begin
				report_mismatch($sformatf("unexpected character %02h last %0b",
					code, last));
			end else begin
				want = expected_chars.pop_front();
				if (code !== want.code) begin
					report_mismatch($sformatf("character %02h, expected %02h",
						code, want.code));
				end
				if (last !== want.last) begin
					report_mismatch($sformatf("last %0b, expected %0b",
						last, want.last));
				end
			end
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                s_axis_tvalid = 1'b0;
	logic                s_axis_tready;
	logic [VALUE_W-1:0]  s_axis_tdata = '0;  // [31:0] value
	logic [OP_W-1:0]     s_axis_tuser = '0;  // [1:0] op
	logic                m_axis_tvalid;
	logic                m_axis_tready = 1'b0;
	logic [CHAR_W-1:0]   m_axis_tdata;       // [7:0] char_code
	logic                m_axis_tlast;

	char_ledger ledger = new();
	int         chars_seen = 0;
	int         cycle_count = 0;
	// Set by the sender for the final stretch, where neither side idles.
	logic       calm = 1'b0;
	logic       hold_done = 1'b0;

	integer_to_ascii_formatter_unit uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	always #10 clk = ~clk;

	// Reset is held at the start and never again.
	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Guard against a hung block.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Every character taken by the receiver is checked. The values read
	// here are the ones present just before the clock edge.
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			ledger.check_char(m_axis_tdata, m_axis_tlast);
			chars_seen++;
		end
	end

	// The receiver. Early on it holds off for a long stretch, so that the
	// block fills up and the sender sees s_axis_tready stay low. Otherwise
	// it stalls in short random bursts, and not at all in the calm stretch.
	initial begin
		@(posedge arst_n);
		forever begin
			if (!hold_done && chars_seen >= 30) begin
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done = 1'b1;
			end else if (!calm && $urandom_range(0, 3) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 5)) @(posedge clk);
			end else begin
				m_axis_tready <= 1'b1;
				repeat (calm ? 1 : $urandom_range(1, 8)) @(posedge clk);
			end
		end
	end

	// Offers one request and returns at the edge where it is accepted.
	// A random gap of idle cycles may come first. The valid is left high,
	// so that a following request is offered without a bubble.
	task send_request(input logic [OP_W-1:0] op, input logic [VALUE_W-1:0] value);
		if (!calm && $urandom_range(0, 2) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= value;
		s_axis_tuser <= op;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		ledger.note_request(op, value);
	endtask

	// A random value, with weight on the short numbers and on the low byte.
	function logic [VALUE_W-1:0] pick_value();
		logic [VALUE_W-1:0] v;
		case ($urandom_range(0, 4))
			0: v = $urandom;
			1: v = $urandom >> $urandom_range(0, 31);
			2: v = $urandom_range(0, 255);
			3: v = {$urandom_range(0, 1) ? 24'hffffff : 24'h000000,
				8'($urandom_range(0, 255))};
			default: v = $urandom_range(0, 99999);
		endcase
		return v;
	endfunction

	function logic [OP_W-1:0] pick_op();
		int roll;
		roll = $urandom_range(0, 9);
		if (roll < 3) return OP_UDEC;
		if (roll < 6) return OP_SBYTE;
		if (roll < 9) return OP_HEX;
		return OP_NONE;
	endfunction

	initial begin
		@(posedge arst_n);
		@(posedge clk);

		// Directed requests: zero and the widest numbers in decimal, a change
		// in digit count, both signs of the low byte with the most negative
		// byte, upper bits that the byte formats must ignore, both ends of
		// the hex digits, and the selector that yields nothing.
		send_request(OP_UDEC, 32'd0);
		send_request(OP_UDEC, 32'd9);
		send_request(OP_UDEC, 32'd10);
		send_request(OP_UDEC, 32'd999999999);
		send_request(OP_UDEC, 32'd1000000000);
		send_request(OP_UDEC, 32'hffffffff);
		send_request(OP_SBYTE, 32'h00000000);
		send_request(OP_SBYTE, 32'h00000001);
		send_request(OP_SBYTE, 32'h0000007f);
		send_request(OP_SBYTE, 32'h00000080);
		send_request(OP_SBYTE, 32'h000000ff);
		send_request(OP_SBYTE, 32'hffffff80);
		send_request(OP_SBYTE, 32'hffffff00);
		send_request(OP_HEX, 32'h00000000);
		send_request(OP_HEX, 32'h000000ff);
		send_request(OP_HEX, 32'h000000a5);
		send_request(OP_HEX, 32'h0000009a);
		send_request(OP_HEX, 32'h12345678);
		send_request(OP_NONE, 32'h00000000);
		send_request(OP_NONE, 32'hffffffff);
		send_request(OP_UDEC, 32'd7);

		for (int i = 0; i < RANDOM_REQUESTS; i++) begin
			if (i == RANDOM_REQUESTS - CALM_REQUESTS) begin
				calm = 1'b1;
			end
			send_request(pick_op(), pick_value());
		end
		s_axis_tvalid <= 1'b0;

		// Wait for every owed character, then a while longer so that a
		// character the block should never have sent would be caught.
		while (ledger.expected_chars.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (ledger.errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
